// ===== hdl/cpd_pkg.sv =====
// shared types, constants and crc helper for the packet deframer
// no dependencies; imported by every other file of the block
package cpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PLEN_W   = 7;
  localparam int unsigned FLEN_W   = 16;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_END_ERR = 2'd2;

  localparam logic REG_SOF = 1'b0;
  localparam logic REG_EOF = 1'b1;

  localparam logic [BYTE_W-1:0] SOF_RST = 8'd170;
  localparam logic [BYTE_W-1:0] EOF_RST = 8'd85;

  typedef enum logic [3:0] {
    PH_WAIT,
    PH_CMD,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_END,
    PH_READ,
    PH_LOAD
  } phase_t;

  typedef enum logic [1:0] {
    RES_BYTE,
    RES_EMPTY,
    RES_CRC_ERR,
    RES_END_ERR
  } res_kind_t;

  typedef struct packed {
    logic      cap_cmd;
    logic      cap_len_lo;
    logic      cap_len_hi;
    logic      wr_data;
    logic      cap_crc_lo;
    logic      cap_crc_hi;
    logic      rd_issue;
    logic      idx_clr;
    logic      idx_inc;
    logic      out_load;
    res_kind_t kind;
  } cpd_cmd_t;

  typedef struct packed {
    logic start_hit;
    logic end_hit;
    logic crc_ok;
    logic len_in_zero;
    logic len_in_big;
    logic len_zero;
    logic data_last;
    logic emit_last;
  } cpd_stat_t;

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cpd_if.sv =====
// valid/ready channel interfaces for received bytes and frame results
// depends on cpd_pkg for field widths
interface cpd_in_if;
  import cpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_out_if;
  import cpd_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   command;
  logic [PLEN_W-1:0]   payload_length;
  logic [BYTE_W-1:0]   payload_byte;
  logic                byte_valid;
  logic                last;

  modport source (output valid, output status, output command, output payload_length,
                  output payload_byte, output byte_valid, output last, input ready);
  modport sink (input valid, input status, input command, input payload_length,
                input payload_byte, input byte_valid, input last, output ready);
endinterface

// ===== hdl/cpd_ctrl.sv =====
// frame parser state machine and output valid register
// depends on cpd_pkg; drives cpd_datapath through cpd_cmd_t
module cpd_ctrl
  import cpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cpd_stat_t stat,
  output cpd_cmd_t  cmd
);

  phase_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   acc;

  assign out_free  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_WAIT:   if (acc && stat.start_hit) state_nxt = PH_CMD;
      PH_CMD:    if (acc) state_nxt = PH_LEN_LO;
      PH_LEN_LO: if (acc) state_nxt = PH_LEN_HI;
      PH_LEN_HI: begin
        if (acc) begin
          priority if (stat.len_in_zero) state_nxt = PH_CRC_LO;
          else if (stat.len_in_big)      state_nxt = PH_WAIT;
          else                           state_nxt = PH_DATA;
        end
      end
      PH_DATA:   if (acc && stat.data_last) state_nxt = PH_CRC_LO;
      PH_CRC_LO: if (acc) state_nxt = PH_CRC_HI;
      PH_CRC_HI: if (acc) state_nxt = PH_END;
      PH_END: begin
        if (acc) begin
          if (stat.end_hit && stat.crc_ok && !stat.len_zero) begin
            state_nxt = PH_READ;
          end else begin
            state_nxt = PH_WAIT;
          end
        end
      end
      PH_READ:   state_nxt = PH_LOAD;
      PH_LOAD: begin
        if (out_free) begin
          state_nxt = stat.emit_last ? PH_WAIT : PH_READ;
        end
      end
      default:   state_nxt = PH_WAIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = RES_BYTE;
    in_ready = 1'b0;
    unique case (state_r)
      PH_WAIT, PH_LEN_LO, PH_CRC_LO: in_ready = 1'b1;
      PH_CMD: begin
        in_ready    = 1'b1;
        cmd.cap_cmd = acc;
      end
      PH_LEN_HI: begin
        in_ready = 1'b1;
        cmd.cap_len_hi = acc;
        cmd.idx_clr    = acc;
      end
      PH_DATA: begin
        in_ready    = 1'b1;
        cmd.wr_data = acc;
      end
      PH_CRC_HI: begin
        in_ready       = 1'b1;
        cmd.cap_crc_hi = acc;
      end
      PH_END: begin
        in_ready = out_free;
        cmd.idx_clr = acc;
        priority if (!stat.end_hit) begin
          cmd.out_load = acc;
          cmd.kind     = RES_END_ERR;
        end else if (!stat.crc_ok) begin
          cmd.out_load = acc;
          cmd.kind     = RES_CRC_ERR;
        end else if (stat.len_zero) begin
          cmd.out_load = acc;
          cmd.kind     = RES_EMPTY;
        end else begin
          cmd.out_load = 1'b0;
        end
      end
      PH_READ:   cmd.rd_issue = 1'b1;
      PH_LOAD: begin
        cmd.out_load = out_free;
        cmd.idx_inc  = out_free;
      end
      default:   in_ready = 1'b0;
    endcase
    cmd.cap_len_lo = (state_r == PH_LEN_LO) && acc;
    cmd.cap_crc_lo = (state_r == PH_CRC_LO) && acc;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/cpd_datapath.sv =====
// frame fields, running crc, payload memory and result register
// depends on cpd_pkg; commanded by cpd_ctrl
module cpd_datapath
  import cpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [BYTE_W-1:0]   in_byte,
  input  logic [BYTE_W-1:0]   sof_byte,
  input  logic [BYTE_W-1:0]   eof_byte,
  input  cpd_cmd_t            cmd,
  output cpd_stat_t           stat,
  output logic [STATUS_W-1:0] out_status,
  output logic [BYTE_W-1:0]   out_command,
  output logic [PLEN_W-1:0]   out_payload_length,
  output logic [BYTE_W-1:0]   out_payload_byte,
  output logic                out_byte_valid,
  output logic                out_last
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [BYTE_W-1:0]   mem [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0]   rd_data_r;
  logic [BYTE_W-1:0]   command_r;
  logic [BYTE_W-1:0]   len_lo_r;
  logic [FLEN_W-1:0]   length_r;
  logic [CRC_W-1:0]    rx_crc_r;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [PLEN_W-1:0]   pos_r, pos_nxt;
  logic [PLEN_W-1:0]   pos_inc;
  logic [FLEN_W-1:0]   len_in;

  logic [STATUS_W-1:0] status_r;
  logic [BYTE_W-1:0]   ocmd_r;
  logic [PLEN_W-1:0]   olen_r;
  logic [BYTE_W-1:0]   obyte_r;
  logic                bvalid_r;
  logic                last_r;

  assign len_in  = {in_byte, len_lo_r};
  assign pos_inc = pos_r + PLEN_W'(1);

  always_comb begin
    stat.start_hit   = (in_byte == sof_byte);
    stat.end_hit     = (in_byte == eof_byte);
    stat.crc_ok      = (crc_r == rx_crc_r);
    stat.len_in_zero = (len_in == '0);
    stat.len_in_big  = (len_in > FLEN_W'(PAYLOAD_DEPTH));
    stat.len_zero    = (length_r == '0);
    stat.data_last   = ({{(FLEN_W-PLEN_W){1'b0}}, pos_inc} >= length_r);
    stat.emit_last   = ({{(FLEN_W-PLEN_W){1'b0}}, pos_inc} == length_r);
  end

  always_comb begin
    crc_nxt = crc_r;
    if (cmd.cap_cmd) begin
      crc_nxt = crc_feed(CRC_INIT, in_byte);
    end else if (cmd.wr_data) begin
      crc_nxt = crc_feed(crc_r, in_byte);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.idx_clr) begin
      pos_nxt = '0;
    end else if (cmd.wr_data || cmd.idx_inc) begin
      pos_nxt = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      pos_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_cmd)    command_r <= in_byte;
    if (cmd.cap_len_lo) len_lo_r  <= in_byte;
    if (cmd.cap_len_hi) length_r  <= len_in;
    if (cmd.cap_crc_lo) rx_crc_r  <= {{(CRC_W-BYTE_W){1'b0}}, in_byte};
    if (cmd.cap_crc_hi) rx_crc_r  <= {in_byte, rx_crc_r[BYTE_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_data) mem[pos_r[AW-1:0]] <= in_byte;
    if (cmd.rd_issue) rd_data_r <= mem[pos_r[AW-1:0]];
  end

  // result register keeps its own command and length while the next frame parses
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ocmd_r <= command_r;
      olen_r <= length_r[PLEN_W-1:0];
      unique case (cmd.kind)
        RES_BYTE: begin
          status_r <= ST_GOOD;
          obyte_r  <= rd_data_r;
          bvalid_r <= 1'b1;
          last_r   <= stat.emit_last;
        end
        RES_EMPTY: begin
          status_r <= ST_GOOD;
          obyte_r  <= '0;
          bvalid_r <= 1'b0;
          last_r   <= 1'b1;
        end
        RES_CRC_ERR: begin
          status_r <= ST_CRC_ERR;
          obyte_r  <= '0;
          bvalid_r <= 1'b0;
          last_r   <= 1'b1;
        end
        RES_END_ERR: begin
          status_r <= ST_END_ERR;
          obyte_r  <= '0;
          bvalid_r <= 1'b0;
          last_r   <= 1'b1;
        end
        default: begin
          status_r <= ST_END_ERR;
          obyte_r  <= '0;
          bvalid_r <= 1'b0;
          last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_status         = status_r;
  assign out_command        = ocmd_r;
  assign out_payload_length = olen_r;
  assign out_payload_byte   = obyte_r;
  assign out_byte_valid     = bvalid_r;
  assign out_last           = last_r;

endmodule

// ===== hdl/crc_packet_deframer_core.sv =====
// Marker-framed packet deframer with CRC-16/MODBUS check.
// in_ch takes one received byte per transaction; out_ch gives one result per
// transaction: one per payload byte of a good frame, or a single result for an
// empty frame, a crc mismatch or a wrong end marker. Frames longer than
// PAYLOAD_DEPTH are dropped without a result.
// While a frame is parsed a byte is taken every cycle. The end byte is taken
// only when the output register is free; an error or empty result shows in
// the cycle after it. For a good frame the payload results follow the end
// byte one at a time, each read from the payload memory into a register, then
// loaded into the output register once it is free. in_ch.ready stays low until
// the last result is loaded. A stalled receiver holds the output register,
// which keeps its own command and length; once the last result is loaded,
// parsing of the next frame goes on meanwhile until its end byte. Reset (rst_n
// low, synchronous) returns the parser to hunting for the start marker, clears
// the output valid and loads the markers to 170 and 85. The user must write
// markers over the cfg_ port only while idle; the block does not enforce it.
// Start marker at address 0, end marker at address 4. No clearing pass.
module crc_packet_deframer_core
  import cpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  cpd_in_if.sink            in_ch,
  cpd_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [BYTE_W-1:0] sof_byte_r;
  logic [BYTE_W-1:0] eof_byte_r;
  logic              cfg_wr;
  cpd_cmd_t          cmd;
  cpd_stat_t         stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_byte_r <= SOF_RST;
      eof_byte_r <= EOF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SOF: sof_byte_r <= cfg_pwdata[BYTE_W-1:0];
        REG_EOF: eof_byte_r <= cfg_pwdata[BYTE_W-1:0];
        default: sof_byte_r <= sof_byte_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SOF: cfg_prdata = {{(CFG_DW-BYTE_W){1'b0}}, sof_byte_r};
      REG_EOF: cfg_prdata = {{(CFG_DW-BYTE_W){1'b0}}, eof_byte_r};
      default: cfg_prdata = '0;
    endcase
  end

  cpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpd_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_byte            (in_ch.rx_byte),
    .sof_byte           (sof_byte_r),
    .eof_byte           (eof_byte_r),
    .cmd                (cmd),
    .stat               (stat),
    .out_status         (out_ch.status),
    .out_command        (out_ch.command),
    .out_payload_length (out_ch.payload_length),
    .out_payload_byte   (out_ch.payload_byte),
    .out_byte_valid     (out_ch.byte_valid),
    .out_last           (out_ch.last)
  );

endmodule

// ===== hdl/cpd_checker.sv =====
// port-level checks for crc_packet_deframer_core, attached by bind
// depends on cpd_pkg and on the top level's ports
module cpd_checker
  import cpd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_byte_valid,
  input logic                out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last)
    else $error("empty or error result not marked last");

  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_GOOD) |-> !out_byte_valid)
    else $error("error result carries a payload byte");

  a_run_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken during a payload run");

endmodule

bind crc_packet_deframer_core cpd_checker u_cpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_byte_valid (out_ch.byte_valid),
  .out_last       (out_ch.last)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for crc_packet_deframer_core: framed byte streams in,
// frame results predicted in-line and checked on every out_ch transaction
// depends on cpd_pkg, cpd_if and the deframer core
module tb_top;
  import cpd_pkg::*;

  localparam int unsigned PAYLOAD_DEPTH = 64;
  localparam int unsigned STUCK_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASE_BYTES   = 60;

  typedef enum {FRM_GOOD, FRM_BAD_CRC, FRM_BAD_END, FRM_TOO_LONG, FRM_CUT} frame_kind_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   command;
    logic [PLEN_W-1:0]   payload_length;
    logic [BYTE_W-1:0]   payload_byte;
    logic                byte_valid;
    logic                last;
  } frame_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  cpd_in_if  in_bus();
  cpd_out_if out_bus();

  crc_packet_deframer_core #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // deframer prediction state
  phase_t            parse_ph;
  logic [BYTE_W-1:0] frm_cmd;
  logic [15:0]       frm_len;
  logic [6:0]        frm_pos;
  logic [CRC_W-1:0]  rx_crc;
  logic [CRC_W-1:0]  run_crc;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0] marker_reg [2];

  logic [BYTE_W-1:0] pending_bytes [$];
  frame_result_t     expected_results [$];

  int unsigned mismatches    = 0;
  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  int unsigned hold_left     = 0;
  int unsigned stuck_cycles  = 0;
  bit          pressure_armed = 1'b0;
  bit          pressure_done  = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [CRC_W-1:0] modbus_crc_byte(logic [CRC_W-1:0] acc,
                                                       logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void push_result(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] data,
                                      logic vld, logic lst);
    frame_result_t r;
    r.status         = st;
    r.command        = frm_cmd;
    r.payload_length = frm_len[PLEN_W-1:0];
    r.payload_byte   = data;
    r.byte_valid     = vld;
    r.last           = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void absorb_rx_byte(logic [BYTE_W-1:0] b);
    case (parse_ph)
      PH_CMD: begin
        frm_cmd  = b;
        run_crc  = modbus_crc_byte(CRC_INIT, b);
        parse_ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frm_len  = {8'h00, b};
        parse_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frm_len[15:8] = b;
        frm_pos       = '0;
        if (frm_len == 0) parse_ph = PH_CRC_LO;
        else if (frm_len > PAYLOAD_DEPTH) parse_ph = PH_WAIT;
        else parse_ph = PH_DATA;
      end
      PH_DATA: begin
        if (frm_pos < PAYLOAD_DEPTH) payload_mem[frm_pos[$clog2(PAYLOAD_DEPTH)-1:0]] = b;
        run_crc = modbus_crc_byte(run_crc, b);
        frm_pos = frm_pos + 7'd1;
        if (16'(frm_pos) >= frm_len) parse_ph = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rx_crc   = {8'h00, b};
        parse_ph = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rx_crc[15:8] = b;
        parse_ph     = PH_END;
      end
      PH_END: begin
        if (b != marker_reg[REG_EOF]) begin
          push_result(ST_END_ERR, 8'h00, 1'b0, 1'b1);
        end else if (run_crc != rx_crc) begin
          push_result(ST_CRC_ERR, 8'h00, 1'b0, 1'b1);
        end else if (frm_len == 0) begin
          push_result(ST_GOOD, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < frm_len && i < PAYLOAD_DEPTH; i++)
            push_result(ST_GOOD, payload_mem[i], 1'b1, (i + 1 == frm_len));
        end
        parse_ph = PH_WAIT;
      end
      default: begin
        parse_ph = (b == marker_reg[REG_SOF]) ? PH_CMD : PH_WAIT;
      end
    endcase
  endfunction

  function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result expected none got status %0h cmd %0h len %0d byte %0h",
               $time, out_bus.status, out_bus.command, out_bus.payload_length,
               out_bus.payload_byte);
    end else begin
      want = expected_results.pop_front();
      report_field("status", 8'(want.status), 8'(out_bus.status));
      report_field("command", want.command, out_bus.command);
      report_field("payload_length", 8'(want.payload_length), 8'(out_bus.payload_length));
      report_field("payload_byte", want.payload_byte, out_bus.payload_byte);
      report_field("byte_valid", 8'(want.byte_valid), 8'(out_bus.byte_valid));
      report_field("last", 8'(want.last), 8'(out_bus.last));
    end
  endfunction

  // builds one frame with the current markers; returns the number of bytes queued
  function automatic int unsigned queue_frame(frame_kind_t kind, logic [BYTE_W-1:0] cmd,
                                              logic [15:0] len);
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] b;
    int unsigned       n_data;
    crc = modbus_crc_byte(CRC_INIT, cmd);
    pending_bytes.push_back(marker_reg[REG_SOF]);
    pending_bytes.push_back(cmd);
    pending_bytes.push_back(len[7:0]);
    pending_bytes.push_back(len[15:8]);
    if (len > PAYLOAD_DEPTH) return 4;
    n_data = (kind == FRM_CUT) ? $urandom_range(0, len) : len;
    for (int i = 0; i < n_data; i++) begin
      b   = 8'($urandom_range(0, 255));
      crc = modbus_crc_byte(crc, b);
      pending_bytes.push_back(b);
    end
    if (kind == FRM_CUT) return 4 + n_data;
    if (kind == FRM_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    pending_bytes.push_back(crc[7:0]);
    pending_bytes.push_back(crc[15:8]);
    b = marker_reg[REG_EOF];
    if (kind == FRM_BAD_END) b = b ^ 8'($urandom_range(1, 255));
    pending_bytes.push_back(b);
    return 7 + n_data;
  endfunction

  task automatic queue_random_traffic(int unsigned target, bit with_max);
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       size_pick;
    logic [15:0]       len;
    logic [BYTE_W-1:0] b;
    frame_kind_t       kind;
    sent = 0;
    if (with_max) sent = queue_frame(FRM_GOOD, 8'($urandom_range(0, 255)), 16'(PAYLOAD_DEPTH));
    while (sent < target) begin
      pick = $urandom_range(1, 100);
      if (pick <= 6) begin
        // raw line noise, may open a stray frame
        repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          b = 8'($urandom_range(0, 255));
          if (b == marker_reg[REG_SOF]) b = ~b;
          pending_bytes.push_back(b);
        end
        if (pick <= 70) kind = FRM_GOOD;
        else if (pick <= 80) kind = FRM_BAD_CRC;
        else if (pick <= 88) kind = FRM_BAD_END;
        else if (pick <= 95) kind = FRM_TOO_LONG;
        else kind = FRM_CUT;
        size_pick = $urandom_range(1, 100);
        if (kind == FRM_TOO_LONG) begin
          if (size_pick <= 50) len = 16'($urandom_range(PAYLOAD_DEPTH + 1, 255));
          else len = 16'($urandom_range(256, 16'hFFFF));
        end else if (size_pick <= 72) begin
          len = 16'($urandom_range(0, 8));
        end else if (size_pick <= 96) begin
          len = 16'($urandom_range(9, PAYLOAD_DEPTH - 1));
        end else begin
          len = 16'(PAYLOAD_DEPTH);
        end
        sent += queue_frame(kind, 8'($urandom_range(0, 255)), len);
      end
    end
  endtask

  task automatic apb_xfer(bit wr, logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] wdata,
                          output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_marker(logic idx);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b0, CFG_AW'({idx, 2'b00}), '0, rd);
    if (rd !== CFG_DW'(marker_reg[idx])) begin
      mismatches++;
      $display("%0t: marker register %0d expected %0h got %0h",
               $time, idx, marker_reg[idx], rd);
    end
  endtask

  task automatic set_marker(logic idx, logic [BYTE_W-1:0] value);
    logic [CFG_DW-1:0] unused_rd;
    apb_xfer(1'b1, CFG_AW'({idx, 2'b00}), CFG_DW'(value), unused_rd);
    marker_reg[idx] = value;
    check_marker(idx);
  endtask

  // drains all traffic; a frame left open is closed with filler bytes
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_bus.valid || expected_results.size() != 0 ||
           parse_ph != PH_WAIT) begin
      if (pending_bytes.size() == 0 && !in_bus.valid && parse_ph != PH_WAIT)
        pending_bytes.push_back(~marker_reg[REG_SOF]);
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // rx driver: one transaction per byte, predicted as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.rx_byte <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) absorb_rx_byte(in_bus.rx_byte);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_bus.valid   <= 1'b1;
          in_bus.rx_byte <= pending_bytes.pop_front();
          if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct)
            gap_left = $urandom_range(1, 12);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_result();
      if (pressure_armed && !pressure_done && out_bus.valid) begin
        hold_left     = LONG_HOLD;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct)
          stall_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, stuck_cycles, expected_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] shared_marker;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    parse_ph       = PH_WAIT;
    frm_cmd        = '0;
    frm_len        = '0;
    frm_pos        = '0;
    rx_crc         = '0;
    run_crc        = CRC_INIT;
    marker_reg[REG_SOF] = SOF_RST;
    marker_reg[REG_EOF] = EOF_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    check_marker(REG_SOF);
    check_marker(REG_EOF);

    // directed: idle garbage, empty frame, oversize, crc error, bad end marker
    @(negedge clk);
    in_gap_pct    = 20;
    out_stall_pct = 20;
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    void'(queue_frame(FRM_GOOD, 8'hFF, 16'd0));
    void'(queue_frame(FRM_TOO_LONG, 8'h00, 16'(PAYLOAD_DEPTH + 1)));
    void'(queue_frame(FRM_BAD_CRC, 8'h5A, 16'd1));
    void'(queue_frame(FRM_BAD_END, 8'h00, 16'd0));
    wait_for_drain();

    set_marker(REG_SOF, 8'h00);
    set_marker(REG_EOF, 8'hFF);
    @(negedge clk);
    in_gap_pct     = 15;
    out_stall_pct  = 25;
    pressure_armed = 1'b1;
    queue_random_traffic(PHASE_BYTES, 1'b0);
    wait_for_drain();

    set_marker(REG_SOF, 8'hFF);
    set_marker(REG_EOF, 8'h00);
    @(negedge clk);
    in_gap_pct    = 30;
    out_stall_pct = 10;
    queue_random_traffic(PHASE_BYTES, 1'b1);
    wait_for_drain();

    shared_marker = 8'($urandom_range(0, 255));
    set_marker(REG_SOF, shared_marker);
    set_marker(REG_EOF, shared_marker);
    @(negedge clk);
    in_gap_pct    = 10;
    out_stall_pct = 40;
    queue_random_traffic(PHASE_BYTES, 1'b0);
    wait_for_drain();

    set_marker(REG_SOF, 8'($urandom_range(0, 255)));
    set_marker(REG_EOF, 8'($urandom_range(0, 255)));
    @(negedge clk);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    queue_random_traffic(PHASE_BYTES, 1'b0);
    wait_for_drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
